FILE: hdl/rmxt_pkg.sv
package rmxt_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int KEY_BITS     = 24;
  localparam int NODE_POOL    = 32768;

  localparam int POS_W  = 11;
  localparam int NODE_W = 15;
  localparam int LVL_W  = 5;
  localparam int POOL_W = 16;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // item kinds
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // datapath operations
  localparam logic [3:0] OP_IDLE     = 4'd0;
  localparam logic [3:0] OP_INIT     = 4'd1;
  localparam logic [3:0] OP_ACCEPT   = 4'd2;
  localparam logic [3:0] OP_CHECK    = 4'd3;
  localparam logic [3:0] OP_AP_START = 4'd4;
  localparam logic [3:0] OP_AP_LVL   = 4'd5;
  localparam logic [3:0] OP_AP_LEAF  = 4'd6;
  localparam logic [3:0] OP_Q_ROOT   = 4'd7;
  localparam logic [3:0] OP_Q_KIDS   = 4'd8;
  localparam logic [3:0] OP_Q_OPP    = 4'd9;
  localparam logic [3:0] OP_Q_LEAF   = 4'd10;
  localparam logic [3:0] OP_Q_PFX    = 4'd11;
  localparam logic [3:0] OP_RES_LOAD = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic lvl_zero;
    logic bad;
    logic is_query;
    logic out_busy;
  } ctl_sts_t;

  // one trie node as stored
  typedef struct packed {
    logic [POS_W-1:0]  newest;
    logic [NODE_W-1:0] c1;
    logic [NODE_W-1:0] c0;
  } node_t;

endpackage

FILE: hdl/rmxt_ctrl.sv
module rmxt_ctrl
  import rmxt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_AP_START = 4'd3;
  localparam logic [3:0] S_AP_LVL   = 4'd4;
  localparam logic [3:0] S_AP_LEAF  = 4'd5;
  localparam logic [3:0] S_Q_ROOT   = 4'd6;
  localparam logic [3:0] S_Q_KIDS   = 4'd7;
  localparam logic [3:0] S_Q_OPP    = 4'd8;
  localparam logic [3:0] S_Q_LEAF   = 4'd9;
  localparam logic [3:0] S_Q_PFX    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        if (sts.bad) state_nxt = S_DONE;
        else if (sts.is_query) state_nxt = S_Q_ROOT;
        else state_nxt = S_AP_START;
      end
      S_AP_START: begin
        cmd.op    = OP_AP_START;
        state_nxt = S_AP_LVL;
      end
      S_AP_LVL: begin
        cmd.op = OP_AP_LVL;
        if (sts.lvl_zero) state_nxt = S_AP_LEAF;
      end
      S_AP_LEAF: begin
        cmd.op    = OP_AP_LEAF;
        state_nxt = S_DONE;
      end
      S_Q_ROOT: begin
        cmd.op    = OP_Q_ROOT;
        state_nxt = S_Q_KIDS;
      end
      S_Q_KIDS: begin
        cmd.op    = OP_Q_KIDS;
        state_nxt = S_Q_OPP;
      end
      S_Q_OPP: begin
        cmd.op    = OP_Q_OPP;
        state_nxt = sts.lvl_zero ? S_Q_LEAF : S_Q_KIDS;
      end
      S_Q_LEAF: begin
        cmd.op    = OP_Q_LEAF;
        state_nxt = S_Q_PFX;
      end
      S_Q_PFX: begin
        cmd.op    = OP_Q_PFX;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_RES_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hdl/rmxt_datapath.sv
module rmxt_datapath
  import rmxt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  input  logic              in_action,
  input  logic [KEY_BITS-1:0] in_value,
  input  logic [POS_W-1:0]  in_left,
  input  logic [POS_W-1:0]  in_right,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [KEY_BITS-1:0] out_best,
  output logic [POS_W-1:0]  out_length
);

  // memories
  node_t               node_mem [0:NODE_POOL-1];
  logic [NODE_W-1:0]   vroot_mem [0:MAX_ELEMENTS];
  logic [KEY_BITS-1:0] pfx_mem [0:MAX_ELEMENTS];

  node_t               node_rdata_r;
  logic [NODE_W-1:0]   vroot_rdata_r;
  logic [KEY_BITS-1:0] pfx_rdata_r;

  logic [NODE_W-1:0]   node_raddr, node_waddr;
  logic                node_we;
  node_t               node_wdata;
  logic [POS_W-1:0]    vroot_raddr, pfx_raddr, ver_waddr;
  logic                ver_we;
  logic [NODE_W-1:0]   vroot_wdata;
  logic [KEY_BITS-1:0] pfx_wdata;

  // block state
  logic [POS_W-1:0]    count_r;
  logic [NODE_W-1:0]   next_free_r;
  logic [NODE_W-1:0]   root_last_r;
  logic [KEY_BITS-1:0] tot_r;
  logic [NODE_W-1:0]   init_k_r;

  // per transaction registers
  logic                is_query_r;
  logic [1:0]          status_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] best_r;
  logic [POS_W-1:0]    lim_r;
  logic [POS_W-1:0]    right_r;
  logic [LVL_W-1:0]    lvl_r;
  logic [NODE_W-1:0]   cur_r, prev_r, opp_r, same_r;

  // output register
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [KEY_BITS-1:0] out_best_r;
  logic [POS_W-1:0]    out_length_r;

  logic [POS_W-1:0]    n_pos;
  logic                kbit;
  node_t               prev_w;
  logic [NODE_W-1:0]   prev_nxt, node_nxt, opp_nxt, same_nxt;
  logic                take_opp;
  logic [1:0]          chk_status;

  assign n_pos  = count_r + POS_W'(1);
  assign kbit   = key_r[lvl_r];
  assign prev_w = (prev_r == '0) ? node_t'('0) : node_rdata_r;
  assign prev_nxt = kbit ? prev_w.c1 : prev_w.c0;
  assign opp_nxt  = kbit ? node_rdata_r.c0 : node_rdata_r.c1;
  assign same_nxt = kbit ? node_rdata_r.c1 : node_rdata_r.c0;
  assign take_opp = (opp_r != '0) && (node_rdata_r.newest >= lim_r);
  assign node_nxt = take_opp ? opp_r : same_r;

  // range and capacity checks on the incoming transaction
  always_comb begin
    chk_status = ST_OK;
    if (in_action == ACT_QUERY) begin
      if (in_left == '0 || in_left > in_right || in_right > count_r) chk_status = ST_RANGE;
    end else begin
      if (count_r == POS_W'(MAX_ELEMENTS) ||
          (POOL_W'(next_free_r) + POOL_W'(KEY_BITS + 1)) > POOL_W'(NODE_POOL))
        chk_status = ST_FULL;
    end
  end

  // memory address and write selection
  always_comb begin
    node_raddr  = '0;
    node_we     = 1'b0;
    node_waddr  = cur_r;
    node_wdata  = '0;
    vroot_raddr = right_r - POS_W'(1);
    pfx_raddr   = node_rdata_r.newest;
    ver_we      = 1'b0;
    ver_waddr   = n_pos;
    vroot_wdata = next_free_r;
    pfx_wdata   = key_r;
    unique case (cmd.op)
      OP_INIT: begin
        node_we    = 1'b1;
        node_waddr = init_k_r;
        node_wdata.c0 = (init_k_r == NODE_W'(KEY_BITS + 1)) ? '0 : init_k_r + NODE_W'(1);
        ver_we      = 1'b1;
        ver_waddr   = '0;
        vroot_wdata = NODE_W'(1);
        pfx_wdata   = '0;
      end
      OP_AP_START: begin
        node_raddr = root_last_r;
        ver_we     = 1'b1;
      end
      OP_AP_LVL: begin
        node_raddr        = prev_nxt;
        node_we           = 1'b1;
        node_wdata.newest = n_pos;
        if (kbit) begin
          node_wdata.c1 = cur_r + NODE_W'(1);
          node_wdata.c0 = prev_w.c0;
        end else begin
          node_wdata.c0 = cur_r + NODE_W'(1);
          node_wdata.c1 = prev_w.c1;
        end
      end
      OP_AP_LEAF: begin
        node_we           = 1'b1;
        node_wdata.newest = n_pos;
      end
      OP_Q_ROOT: node_raddr = vroot_rdata_r;
      OP_Q_KIDS: node_raddr = opp_nxt;
      OP_Q_OPP:  node_raddr = node_nxt;
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata_r <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (ver_we) begin
      vroot_mem[ver_waddr] <= vroot_wdata;
      pfx_mem[ver_waddr]   <= pfx_wdata;
    end
    vroot_rdata_r <= vroot_mem[vroot_raddr];
    pfx_rdata_r   <= pfx_mem[pfx_raddr];
  end

  // block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_free_r <= NODE_W'(KEY_BITS + 2);
      root_last_r <= NODE_W'(1);
      tot_r       <= '0;
      init_k_r    <= NODE_W'(1);
    end else begin
      if (cmd.op == OP_INIT) init_k_r <= init_k_r + NODE_W'(1);
      if (cmd.op == OP_AP_START) root_last_r <= next_free_r;
      if (cmd.op == OP_AP_LEAF) begin
        next_free_r <= cur_r + NODE_W'(1);
        count_r     <= n_pos;
        tot_r       <= key_r;
      end
    end
  end

  // transaction registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        is_query_r <= in_action;
        status_r   <= chk_status;
        key_r      <= tot_r ^ in_value;
        lim_r      <= in_left - POS_W'(1);
        right_r    <= in_right;
        best_r     <= '0;
      end
      OP_CHECK: lvl_r <= LVL_W'(KEY_BITS - 1);
      OP_AP_START: begin
        cur_r  <= next_free_r;
        prev_r <= root_last_r;
      end
      OP_AP_LVL: begin
        cur_r  <= cur_r + NODE_W'(1);
        prev_r <= prev_nxt;
        lvl_r  <= lvl_r - LVL_W'(1);
      end
      OP_Q_KIDS: begin
        opp_r  <= opp_nxt;
        same_r <= same_nxt;
      end
      OP_Q_OPP: lvl_r <= lvl_r - LVL_W'(1);
      OP_Q_PFX: best_r <= key_r ^ pfx_rdata_r;
      default: ;
    endcase
  end

  // result register towards the output channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_RES_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RES_LOAD) begin
      out_status_r <= status_r;
      out_best_r   <= best_r;
      out_length_r <= count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_best   = out_best_r;
  assign out_length = out_length_r;

  assign sts.init_last = (init_k_r == NODE_W'(KEY_BITS + 1));
  assign sts.lvl_zero  = (lvl_r == '0);
  assign sts.bad       = (status_r != ST_OK);
  assign sts.is_query  = is_query_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

FILE: hdl/range_max_xor_persistent_trie_unit.sv
// Range maximum XOR over a growing sequence of 24-bit values, held as prefix
// XORs in a persistent binary trie of up to 32768 nodes (1024 elements). After
// reset the unit builds the empty version and holds in_tready low. One
// transaction is handled at a time: an append does a node memory read and
// write per trie level, a query two dependent node memory reads per level,
// then the prefix lookup, and an error goes straight to the result. A finished
// result sits in the output register while the next transaction is accepted.
// Every transaction gives exactly one result: status, best XOR (zero for
// appends and errors) and element count.
module range_max_xor_persistent_trie_unit
  import rmxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // value[23:0], left_pos[34:24], right_pos[45:35], zero pad
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // best_xor[23:0], length_now[34:24], zero pad
  output logic [1:0]  out_tuser  // status
);

  ctl_cmd_t            cmd;
  ctl_sts_t            sts;
  logic [KEY_BITS-1:0] best;
  logic [POS_W-1:0]    length_now;

  // sequencing
  rmxt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // trie storage and arithmetic
  rmxt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (in_tuser),
    .in_value   (in_tdata[23:0]),
    .in_left    (in_tdata[34:24]),
    .in_right   (in_tdata[45:35]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_best   (best),
    .out_length (length_now)
  );

  assign out_tdata = {5'd0, length_now, best};

endmodule
